FILE: hdl/sbd_pkg.sv
// Shared types and constants for the spectral beat detector.
package sbd_pkg;
  localparam int HISTORY_DEPTH = 128;
  localparam int SAMPLE_WIDTH  = 24;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int WIN_W         = HIST_AW + 1;
  localparam int SQ_W          = 48;
  localparam int ROOT_STEPS    = SQ_W / 2;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [SAMPLE_WIDTH-1:0] PEAK_MAX = '1;

  localparam logic [1:0] REG_BAND_LOW  = 2'd0;
  localparam logic [1:0] REG_BAND_HIGH = 2'd1;
  localparam logic [1:0] REG_WINDOW    = 2'd2;

  typedef struct packed {
    logic                    in_band;
    logic                    last;
    logic [SQ_W-1:0]         mag_sq;
  } sbd_job_t;

  typedef struct packed {
    logic [WIN_W-1:0] win;
  } sbd_cfg_t;
endpackage

FILE: hdl/sbd_ram.sv
// Generic single-port RAM with registered read.
module sbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hdl/sbd_front.sv
// Front end: band check and squared magnitude, pushed into the job queue.
module sbd_front import sbd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [11:0]            bin_index,
  input  logic signed [23:0]     real_part,
  input  logic signed [23:0]     imag_part,
  input  logic                   last_bin,
  input  logic [11:0]            band_low_bin,
  input  logic [11:0]            band_high_bin,
  output logic                   job_valid,
  output sbd_job_t               job,
  input  logic                   job_take
);
  // stage 1: absolute values and band flag
  logic        s1_valid;
  logic [23:0] s1_re, s1_im;
  logic        s1_band, s1_last;
  // stage 2: squares
  logic        s2_valid;
  logic [47:0] s2_re2, s2_im2;
  logic        s2_band, s2_last;

  sbd_job_t             q [QUEUE_DEPTH];
  logic [0:0]           q_rd, q_wr;
  logic [1:0]           q_cnt;
  logic [1:0]           inflight;
  logic                 accept, q_push, q_pop;

  // Only accept when the queue is sure to have room for everything in flight.
  assign full   = (2'(q_cnt) + inflight) >= 2'(QUEUE_DEPTH);
  assign accept = push && !full;
  assign q_push = s2_valid;
  assign q_pop  = job_take && job_valid;
  assign job_valid = q_cnt != 2'd0;
  assign job       = q[q_rd];
  assign inflight  = {1'b0, s1_valid} + {1'b0, s2_valid};

  always_ff @(posedge clk) begin
    s1_re   <= real_part[23] ? 24'(-real_part) : real_part;
    s1_im   <= imag_part[23] ? 24'(-imag_part) : imag_part;
    s1_band <= (bin_index >= band_low_bin) && (bin_index < band_high_bin);
    s1_last <= last_bin;
    s2_re2  <= s1_re * s1_re;
    s2_im2  <= s1_im * s1_im;
    s2_band <= s1_band;
    s2_last <= s1_last;
    if (q_push) begin
      q[q_wr] <= '{in_band: s2_band, last: s2_last, mag_sq: s2_re2 + s2_im2};
    end
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      q_rd     <= '0;
      q_wr     <= '0;
      q_cnt    <= '0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (q_push) q_wr <= q_wr + 1'b1;
      if (q_pop)  q_rd <= q_rd + 1'b1;
      q_cnt <= q_cnt + {1'b0, q_push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (!(q_push && !q_pop && q_cnt == 2'(QUEUE_DEPTH)))
        else $error("job queue overflow");
      assert (!(q_pop && q_cnt == 2'd0)) else $error("job queue underflow");
    end
  end

  ap_inflight: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid) else $error("stage 1 lost an item");
  ap_cnt: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= 2'(QUEUE_DEPTH)) else $error("queue count out of range");
  ap_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> s2_valid) else $error("stage 2 lost an item");
endmodule

FILE: hdl/sbd_back.sv
// Back end: iterative root, history ring, window scan and beat decision.
module sbd_back import sbd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    job_valid,
  input  sbd_job_t                job,
  output logic                    job_take,
  input  sbd_cfg_t                cfg,
  output logic                    res_valid,
  input  logic                    res_taken,
  output logic                    beat,
  output logic [31:0]             beat_number,
  output logic [SAMPLE_WIDTH-1:0] frame_peak,
  output logic [SAMPLE_WIDTH-1:0] window_max,
  output logic [SAMPLE_WIDTH-1:0] window_min,
  output logic                    armed
);
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ROOT, S_WRITE, S_SCAN, S_WAIT, S_DECIDE, S_OUT
  } state_t;

  state_t                  state;
  logic [SQ_W-1:0]         rem;
  logic [SQ_W-1:0]         root;
  logic [SQ_W-1:0]         bitv;
  logic                    cur_last;
  logic [SAMPLE_WIDTH-1:0] running_peak;
  logic [HIST_AW-1:0]      wpos;
  logic [WIN_W-1:0]        scan_cnt;
  logic                    scan_rd;
  logic [SAMPLE_WIDTH-1:0] mx, mn;
  logic                    armed_flag;
  logic [31:0]             beat_total;

  logic                    ram_we;
  logic [HIST_AW-1:0]      ram_addr;
  logic [SAMPLE_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [SQ_W-1:0]         trial;
  logic [SAMPLE_WIDTH-1:0] root_sat, diff, thr_hi, thr_lo;
  logic [HIST_AW-1:0]      wpos_use;

  assign trial    = root + bitv;
  assign root_sat = (root > SQ_W'(PEAK_MAX)) ? PEAK_MAX : root[SAMPLE_WIDTH-1:0];
  assign wpos_use = (WIN_W'(wpos) >= cfg.win) ? '0 : wpos;
  assign diff     = (mx - mn) >> 2;
  assign thr_hi   = mx - diff;
  assign thr_lo   = mx - (diff << 1);
  assign job_take = (state == S_IDLE) && job_valid;
  assign res_valid = (state == S_OUT);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = scan_cnt[HIST_AW-1:0];
    ram_wdata = running_peak;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = wpos_use;
      end
      default: ;
    endcase
  end

  sbd_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      scan_cnt     <= '0;
      scan_rd      <= 1'b0;
      running_peak <= '0;
      wpos         <= '0;
      armed_flag   <= 1'b1;
      beat_total   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == WIN_W'(HISTORY_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (job_valid) begin
            cur_last <= job.last;
            rem      <= job.mag_sq;
            root     <= '0;
            bitv     <= SQ_W'(1) << (SQ_W - 2);
            if (job.in_band) begin
              state <= S_ROOT;
            end else if (job.last) begin
              state <= S_WRITE;
            end
          end
        end
        S_ROOT: begin
          // one result bit per cycle
          if (rem >= trial) begin
            rem  <= rem - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv == SQ_W'(1)) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (root_sat > running_peak) begin
            running_peak <= root_sat;
          end
          state <= cur_last ? S_WRITE : S_IDLE;
        end
        S_WRITE: begin
          wpos     <= (WIN_W'(wpos_use) + 1'b1 >= cfg.win) ? '0 : wpos_use + 1'b1;
          scan_cnt <= '0;
          scan_rd  <= 1'b0;
          mx       <= '0;
          mn       <= PEAK_MAX;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          // read data returns in the cycle after its address
          if (scan_rd) begin
            if (ram_rdata > mx) mx <= ram_rdata;
            if (ram_rdata < mn) mn <= ram_rdata;
          end
          if (scan_cnt == cfg.win) begin
            state <= S_DECIDE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
            scan_rd  <= 1'b1;
          end
        end
        S_DECIDE: begin
          beat        <= 1'b0;
          beat_number <= beat_total;
          frame_peak  <= running_peak;
          window_max  <= mx;
          window_min  <= mn;
          armed       <= armed_flag;
          if (armed_flag) begin
            if (running_peak > thr_hi) begin
              beat        <= 1'b1;
              beat_total  <= beat_total + 1'b1;
              armed_flag  <= 1'b0;
              armed       <= 1'b0;
            end
          end else if (running_peak < thr_lo) begin
            armed_flag <= 1'b1;
            armed      <= 1'b1;
          end
          running_peak <= '0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_taken) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_take: assert property (@(posedge clk) disable iff (rst)
    job_take |-> state == S_IDLE) else $error("job taken while busy");
  ap_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !res_taken) |=> state == S_OUT) else $error("result dropped");
  ap_order: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |=> mn <= mx || cfg.win == '0) else $error("min above max");
endmodule

FILE: hdl/spectral_beat_detector.sv
// Top level of the spectral beat detector: config registers, front and back ends.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  bins in  | push / full          | bin_index, real_part, imag_part, last_bin
//  result   | empty / pop          | beat, beat_number, frame_peak, window_*,
//           |                      | armed
//  config   | APB psel/penable/... | band_low_bin, band_high_bin, window_length
//
// An in-band bin is taken, then goes through 24 root steps and a peak update;
// an out-of-band bin is only taken. A last bin then adds a history write, a
// scan of the window on the single RAM port and a decision, win being
// window_length clamped to 1..HISTORY_DEPTH. After reset the history is
// cleared entry by entry; bins queue up in the front end meanwhile.
// A stalled result holds the back end; the front fills its two-entry queue.
module spectral_beat_detector import sbd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [11:0]             bin_index,
  input  logic signed [23:0]      real_part,
  input  logic signed [23:0]      imag_part,
  input  logic                    last_bin,
  output logic                    empty,
  input  logic                    pop,
  output logic                    beat,
  output logic [31:0]             beat_number,
  output logic [SAMPLE_WIDTH-1:0] frame_peak,
  output logic [SAMPLE_WIDTH-1:0] window_max,
  output logic [SAMPLE_WIDTH-1:0] window_min,
  output logic                    armed,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  logic [11:0] band_low_bin, band_high_bin;
  logic [7:0]  window_length;
  logic        wr;
  logic [1:0]  reg_sel;
  logic        job_valid, job_take, res_valid;
  sbd_job_t    job;
  sbd_cfg_t    cfg;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // register file: 4-byte spacing
  always_ff @(posedge clk) begin
    if (rst) begin
      band_low_bin  <= 12'd4;
      band_high_bin <= 12'd8;
      window_length <= 8'd100;
    end else if (wr) begin
      case (reg_sel)
        REG_BAND_LOW:  band_low_bin  <= pwdata[11:0];
        REG_BAND_HIGH: band_high_bin <= pwdata[11:0];
        REG_WINDOW:    window_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BAND_LOW:  prdata = {20'd0, band_low_bin};
      REG_BAND_HIGH: prdata = {20'd0, band_high_bin};
      REG_WINDOW:    prdata = {24'd0, window_length};
      default:       prdata = '0;
    endcase
  end

  // window clamped to 1..HISTORY_DEPTH
  always_comb begin
    if (window_length == 8'd0) begin
      cfg.win = WIN_W'(1);
    end else if (9'(window_length) > 9'(HISTORY_DEPTH)) begin
      cfg.win = WIN_W'(HISTORY_DEPTH);
    end else begin
      cfg.win = WIN_W'(window_length);
    end
  end

  sbd_front u_front (
    .clk, .rst, .push, .full, .bin_index, .real_part, .imag_part, .last_bin,
    .band_low_bin, .band_high_bin, .job_valid, .job, .job_take
  );

  sbd_back u_back (
    .clk, .rst, .job_valid, .job, .job_take, .cfg,
    .res_valid, .res_taken(pop), .beat, .beat_number, .frame_peak,
    .window_max, .window_min, .armed
  );

  assign empty = !res_valid;
endmodule

FILE: tb/spectral_beat_detector_tb.sv
// Testbench for spectral_beat_detector: random spectrum frames checked against a predictor.
module spectral_beat_detector_tb;
  import sbd_pkg::*;

  // Expected content of one frame result.
  typedef struct {
    logic                    beat;
    logic [31:0]             beat_number;
    logic [SAMPLE_WIDTH-1:0] frame_peak;
    logic [SAMPLE_WIDTH-1:0] window_max;
    logic [SAMPLE_WIDTH-1:0] window_min;
    logic                    armed;
  } frame_result_t;

  // Beat tracker: own copy of the history, band and window settings, and
  // the queue of frame results still owed by the block.
  class beat_scoreboard;
    logic [SAMPLE_WIDTH-1:0] history[HISTORY_DEPTH];
    int unsigned             wr_pos;
    logic [SAMPLE_WIDTH-1:0] peak_so_far;
    logic                    is_armed;
    logic [31:0]             beats;
    logic [11:0]             lo_bin, hi_bin;
    logic [7:0]              win_len;
    frame_result_t           owed[$];
    int                      errors;

    function new();
      foreach (history[i]) history[i] = '0;
      wr_pos = 0;
      peak_so_far = '0;
      is_armed = 1'b1;
      beats = '0;
      lo_bin = 12'd4;
      hi_bin = 12'd8;
      win_len = 8'd100;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_BAND_LOW:  lo_bin = val[11:0];
        REG_BAND_HIGH: hi_bin = val[11:0];
        REG_WINDOW:    win_len = val[7:0];
        default: ;
      endcase
    endfunction

    // floor(sqrt(v)), bit-pair method, clamped to the peak width
    function logic [SAMPLE_WIDTH-1:0] magnitude(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      if (r > PEAK_MAX) r = PEAK_MAX;
      return r[SAMPLE_WIDTH-1:0];
    endfunction

    function void note_bin(logic [11:0] idx, logic signed [23:0] re,
                           logic signed [23:0] im, logic last);
      longint          sr, si;
      longint unsigned sq;
      logic [SAMPLE_WIDTH-1:0] mag, mx, mn, diff;
      int unsigned     win;
      frame_result_t   r;
      if (idx >= lo_bin && idx < hi_bin) begin
        sr = re;
        si = im;
        if (sr < 0) sr = -sr;
        if (si < 0) si = -si;
        sq = sr * sr + si * si;
        mag = magnitude(sq);
        if (mag > peak_so_far) peak_so_far = mag;
      end
      if (!last) return;
      win = win_len;
      if (win == 0) win = 1;
      if (win > HISTORY_DEPTH) win = HISTORY_DEPTH;
      if (wr_pos >= win) wr_pos = 0;   // window shrank under the pointer
      history[wr_pos] = peak_so_far;
      wr_pos = (wr_pos + 1) % win;
      mx = '0;
      mn = PEAK_MAX;
      for (int i = 0; i < win; i++) begin
        if (history[i] > mx) mx = history[i];
        if (history[i] < mn) mn = history[i];
      end
      diff = (mx - mn) >> 2;
      r.beat = 1'b0;
      r.beat_number = beats;
      if (is_armed) begin
        if (peak_so_far > mx - diff) begin
          r.beat = 1'b1;
          beats++;
          is_armed = 1'b0;
        end
      end else if (peak_so_far < mx - 2 * diff) begin
        is_armed = 1'b1;
      end
      r.frame_peak = peak_so_far;
      r.window_max = mx;
      r.window_min = mn;
      r.armed = is_armed;
      owed.push_back(r);
      peak_so_far = '0;
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (owed.size() == 0) begin
        $display("%0t: result with none expected: peak %0d beat %0b", $time,
                 got.frame_peak, got.beat);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.beat !== want.beat) begin
        $display("%0t: beat exp %0b got %0b", $time, want.beat, got.beat);
        errors++;
      end
      if (got.beat_number !== want.beat_number) begin
        $display("%0t: beat_number exp %0d got %0d", $time, want.beat_number,
                 got.beat_number);
        errors++;
      end
      if (got.frame_peak !== want.frame_peak) begin
        $display("%0t: frame_peak exp %0d got %0d", $time, want.frame_peak,
                 got.frame_peak);
        errors++;
      end
      if (got.window_max !== want.window_max) begin
        $display("%0t: window_max exp %0d got %0d", $time, want.window_max,
                 got.window_max);
        errors++;
      end
      if (got.window_min !== want.window_min) begin
        $display("%0t: window_min exp %0d got %0d", $time, want.window_min,
                 got.window_min);
        errors++;
      end
      if (got.armed !== want.armed) begin
        $display("%0t: armed exp %0b got %0b", $time, want.armed, got.armed);
        errors++;
      end
    endfunction
  endclass

  logic                    clk, rst;
  logic                    push, full, empty, pop;
  logic [11:0]             bin_index;
  logic signed [23:0]      real_part, imag_part;
  logic                    last_bin;
  logic                    beat, armed;
  logic [31:0]             beat_number;
  logic [SAMPLE_WIDTH-1:0] frame_peak, window_max, window_min;
  logic                    psel, penable, pwrite, pready;
  logic [3:0]              paddr;
  logic [31:0]             pwdata, prdata;

  spectral_beat_detector dut (.*);

  beat_scoreboard sb;
  bit quiet;          // no idling on either side near the end
  int long_hold;      // 1: receiver should hold off, 2: done

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Runaway guard, far beyond the slowest legal run.
  initial begin
    #80000000;
    $display("TB_ERROR");
    $finish;
  end

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one bin, possibly after a random gap; returns once it is taken.
  task automatic send_bin(logic [11:0] idx, logic [23:0] re, logic [23:0] im,
                          logic last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    push <= 1'b1;
    bin_index <= idx;
    real_part <= re;
    imag_part <= im;
    last_bin <= last;
    do @(posedge clk); while (full);
    sb.note_bin(idx, re, im, last);
  endtask

  // Wait for the owed results to drain and the back end to go idle.
  task automatic drain();
    push <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Component value: mostly scaled so peaks vary frame to frame, sometimes
  // full random to toggle every bit.
  function automatic logic [23:0] component(int unsigned scale);
    logic [23:0] v;
    if ($urandom_range(0, 5) == 0) return 24'($urandom);
    v = 24'($urandom_range(0, 24'h7FFFFF) >> scale);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // One well-formed frame: a few bins around the band, the last one flagged.
  task automatic random_frame(int unsigned lo, int unsigned hi);
    int unsigned n, scale, idx;
    n = $urandom_range(1, 6);
    scale = $urandom_range(0, 23);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        idx = $urandom_range(0, 4095);
      else begin
        idx = $urandom_range((lo > 2) ? lo - 2 : 0, hi + 2);
        if (idx > 4095) idx = 4095;
      end
      send_bin(12'(idx), component(scale), component(scale), k == n - 1);
    end
  endtask

  // Receiver: random pop bursts, one long hold-off on request.
  initial begin
    int idle_left;
    frame_result_t got;
    idle_left = 0;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      if (idle_left > 0) begin
        pop <= 1'b0;
        idle_left--;
      end else if (long_hold == 1) begin
        idle_left = 600;     // long enough to back up the input queue
        long_hold = 2;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(1, 19);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) begin
        got.beat = beat;
        got.beat_number = beat_number;
        got.frame_peak = frame_peak;
        got.window_max = window_max;
        got.window_min = window_min;
        got.armed = armed;
        sb.check_result(got);
      end
    end
  end

  // Band and window settings per random phase: full band, empty band,
  // window zero, window above depth, window lowered, empty top band, narrow band.
  int phase_lo[7]  = '{0, 10, 3, 2, 0, 4095, 1};
  int phase_hi[7]  = '{4095, 5, 9, 6, 16, 4095, 3};
  int phase_win[7] = '{128, 1, 0, 255, 7, 3, 40};

  initial begin
    sb = new();
    quiet = 1'b0;
    long_hold = 0;
    rst = 1'b1;
    push = 1'b0;
    bin_index = '0;
    real_part = '0;
    imag_part = '0;
    last_bin = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames at the reset band 4..8, window 100.
    send_bin(12'd0, 24'h800000, 24'h800000, 1'b0);     // below band
    send_bin(12'd4, 24'h800000, 24'h800000, 1'b0);     // largest magnitude
    send_bin(12'd7, 24'h7FFFFF, 24'h000000, 1'b0);     // top bin of band
    send_bin(12'd8, 24'h7FFFFF, 24'h7FFFFF, 1'b0);     // band end, excluded
    send_bin(12'd4095, 24'h7FFFFF, 24'h800000, 1'b0);
    send_bin(12'd5, 24'h000000, 24'h000000, 1'b1);
    send_bin(12'd4, 24'h000000, 24'h000000, 1'b1);     // zero peak
    send_bin(12'd6, 24'd3, 24'd4, 1'b1);
    send_bin(12'd5, 24'h800000, 24'h000000, 1'b1);
    send_bin(12'd4095, 24'hFFFFFF, 24'hFFFFFF, 1'b1);  // last bin out of band
    send_bin(12'd6, 24'hFFFFFF, 24'h000001, 1'b0);
    send_bin(12'd7, 24'h000001, 24'hFFFFFF, 1'b1);
    send_bin(12'd4, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
    send_bin(12'd5, 24'h000100, 24'h000000, 1'b1);
    drain();

    for (int p = 0; p < 7; p++) begin
      write_reg(REG_BAND_LOW, phase_lo[p]);
      write_reg(REG_BAND_HIGH, phase_hi[p]);
      write_reg(REG_WINDOW, phase_win[p]);
      if (p == 1) long_hold = 1;
      if (p == 6) quiet = 1'b1;
      for (int n = 0; n < 280; n += 4)
        random_frame(phase_lo[p], phase_hi[p]);
      drain();
    end

    if (sb.owed.size() != 0)
      sb.errors++;
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: spectral_beat_detector.f
hdl/sbd_pkg.sv
hdl/sbd_ram.sv
hdl/sbd_front.sv
hdl/sbd_back.sv
hdl/spectral_beat_detector.sv
tb/spectral_beat_detector_tb.sv
